FILE: src/sncr_pkg.sv
`default_nettype none
package sncr_pkg;

  localparam int ResultBitsDef  = 10;
  localparam int NibblesSentDef = 3;

  localparam int CfgIdxW   = 3;
  localparam int RegW      = 8;
  localparam int NibW      = 4;
  localparam int SampleW   = 10;
  localparam int NibIdxW   = 2;
  localparam int PhaseW    = 3;

  localparam logic [CfgIdxW-1:0] RegSettleTicks  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWaitLimit    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHoldTicks    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegLedThreshold = 3'd3;

  localparam logic [RegW-1:0] SettleTicksRst  = 8'd10;
  localparam logic [RegW-1:0] WaitLimitRst    = 8'd10;
  localparam logic [RegW-1:0] HoldTicksRst    = 8'd10;
  localparam logic [RegW-1:0] LedThresholdRst = 8'd127;

  localparam logic [NibW-1:0] CmdReset  = 4'h0;
  localparam logic [NibW-1:0] CmdPing   = 4'h1;
  localparam logic [NibW-1:0] CmdGet    = 4'h2;
  localparam logic [NibW-1:0] AckNibble = 4'hE;

  typedef struct packed {
    logic [NibW-1:0] data_out;
    logic            drive_enable;
    logic            led;
    logic            busy_res;
  } result_t;

endpackage
`default_nettype wire

FILE: src/strobe_nibble_command_responder.sv
`default_nettype none
// Strobe/nibble command responder. Every input word is one sampled tick of the
// host strobe, the 4-bit bus and an optional converter sample; every accepted
// word yields exactly one output word with the bus drive, LED and busy state
// after that tick. A word is accepted each cycle (one per clock sustained) and
// its result appears in the output register on the next cycle; the tick state
// machine updates once per accepted word, and an unread result only stalls
// input when the output register is full and not being taken.
// Configuration writes are always accepted and must only be issued while idle.
module strobe_nibble_command_responder
  import sncr_pkg::*;
#(
  parameter int RESULT_BITS  = ResultBitsDef,
  parameter int NIBBLES_SENT = NibblesSentDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic               strobe_req_i,
  input  wire logic [NibW-1:0]    data_in_i,
  input  wire logic               sample_valid_i,
  input  wire logic [SampleW-1:0] sample_value_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [NibW-1:0]    data_out_o,
  output      logic               drive_enable_o,
  output      logic               led_o,
  output      logic               busy_res_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [RegW-1:0]    cfg_data_i
);

  localparam logic [PhaseW-1:0] PhIdle  = 3'd0;
  localparam logic [PhaseW-1:0] PhSettle = 3'd1;
  localparam logic [PhaseW-1:0] PhAck   = 3'd2;
  localparam logic [PhaseW-1:0] PhWait  = 3'd3;
  localparam logic [PhaseW-1:0] PhNhold = 3'd4;

  localparam int LedRsh = (RESULT_BITS >= 8) ? RESULT_BITS - 8 : 0;
  localparam int LedLsh = (RESULT_BITS < 8) ? 8 - RESULT_BITS : 0;
  localparam logic [NibIdxW-1:0] NibCount = NibIdxW'(NIBBLES_SENT);

  logic [RegW-1:0] settle_q, wait_lim_q, hold_q, led_thr_q;

  logic                   strobe_seen_q, strobe_seen_d;
  logic [NibW-1:0]        cmd_q, cmd_d;
  logic [PhaseW-1:0]      phase_q, phase_d;
  logic [RegW-1:0]        tick_q, tick_d;
  logic [NibIdxW-1:0]     nib_idx_q, nib_idx_d;
  logic [RESULT_BITS-1:0] shift_q, shift_d;
  logic                   strobe_snd_q, strobe_snd_d;
  logic [RESULT_BITS-1:0] held_q, held_d;
  logic [NibW-1:0]        nib_q, nib_d;
  logic                   drive_q, drive_d;

  logic           out_valid_q;
  result_t        res_q, res_d;
  logic           in_fire;
  logic [15:0]    held_ext;
  logic [RegW-1:0] upper;
  logic [RegW-1:0] tick_inc;
  logic [NibIdxW-1:0] idx_inc;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q  <= SettleTicksRst;
      wait_lim_q <= WaitLimitRst;
      hold_q    <= HoldTicksRst;
      led_thr_q <= LedThresholdRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegSettleTicks:  settle_q   <= cfg_data_i;
        RegWaitLimit:    wait_lim_q <= cfg_data_i;
        RegHoldTicks:    hold_q     <= cfg_data_i;
        RegLedThreshold: led_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    held_d        = sample_valid_i ? RESULT_BITS'(sample_value_i) : held_q;
    strobe_seen_d = strobe_seen_q;
    cmd_d         = cmd_q;
    phase_d       = phase_q;
    tick_d        = tick_q;
    nib_idx_d     = nib_idx_q;
    shift_d       = shift_q;
    strobe_snd_d  = strobe_snd_q;
    nib_d         = nib_q;
    drive_d       = drive_q;
    tick_inc      = tick_q + 8'd1;
    idx_inc       = nib_idx_q + 2'd1;

    unique case (phase_q)
      PhSettle: begin
        if (tick_q <= 8'd1) begin
          tick_d        = 8'd0;
          cmd_d         = data_in_i;
          strobe_seen_d = 1'b1;
          phase_d       = PhIdle;
        end else begin
          tick_d = tick_q - 8'd1;
        end
      end
      PhAck: begin
        if (tick_q == 8'd0) begin
          drive_d = 1'b0;
          phase_d = PhIdle;
        end else begin
          tick_d = tick_q - 8'd1;
        end
      end
      PhWait: begin
        if (strobe_req_i != strobe_snd_q || tick_inc >= wait_lim_q) begin
          tick_d  = hold_q;
          phase_d = PhNhold;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhNhold: begin
        if (tick_q == 8'd0) begin
          if (idx_inc >= NibCount) begin
            nib_idx_d = '0;
            drive_d   = 1'b0;
            phase_d   = PhIdle;
          end else begin
            nib_idx_d    = idx_inc;
            nib_d        = shift_q[NibW-1:0];
            shift_d      = shift_q >> NibW;
            strobe_snd_d = strobe_req_i;
            drive_d      = 1'b1;
            tick_d       = 8'd0;
            phase_d      = PhWait;
          end
        end else begin
          tick_d = tick_q - 8'd1;
        end
      end
      default: begin
        phase_d = PhIdle;
        if (strobe_req_i && !strobe_seen_q) begin
          if (settle_q == 8'd0) begin
            cmd_d         = data_in_i;
            strobe_seen_d = 1'b1;
          end else begin
            tick_d  = settle_q;
            phase_d = PhSettle;
          end
        end else if (!strobe_req_i && strobe_seen_q) begin
          strobe_seen_d = 1'b0;
          if (cmd_q == CmdReset || cmd_q == CmdPing) begin
            if (cmd_q == CmdReset) begin
              held_d = '0;
            end
            nib_d   = AckNibble;
            drive_d = 1'b1;
            tick_d  = hold_q;
            phase_d = PhAck;
          end else if (cmd_q == CmdGet) begin
            nib_idx_d    = '0;
            nib_d        = held_d[NibW-1:0];
            shift_d      = held_d >> NibW;
            strobe_snd_d = strobe_req_i;
            drive_d      = 1'b1;
            tick_d       = 8'd0;
            phase_d      = PhWait;
          end
        end
      end
    endcase

    held_ext          = 16'(held_d);
    upper             = RegW'((held_ext >> LedRsh) << LedLsh);
    res_d.data_out    = drive_d ? nib_d : '0;
    res_d.drive_enable = drive_d;
    res_d.led         = upper < led_thr_q;
    res_d.busy_res    = phase_d != PhIdle;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_seen_q <= 1'b0;
      cmd_q         <= '0;
      phase_q       <= PhIdle;
      tick_q        <= '0;
      nib_idx_q     <= '0;
      shift_q       <= '0;
      strobe_snd_q  <= 1'b0;
      held_q        <= '0;
      nib_q         <= '0;
      drive_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        strobe_seen_q <= strobe_seen_d;
        cmd_q         <= cmd_d;
        phase_q       <= phase_d;
        tick_q        <= tick_d;
        nib_idx_q     <= nib_idx_d;
        shift_q       <= shift_d;
        strobe_snd_q  <= strobe_snd_d;
        held_q        <= held_d;
        nib_q         <= nib_d;
        drive_q       <= drive_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign data_out_o     = res_q.data_out;
  assign drive_enable_o = res_q.drive_enable;
  assign led_o          = res_q.led;
  assign busy_res_o     = res_q.busy_res;

`ifndef SYNTHESIS
  a_drive_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q |-> (phase_q == PhAck || phase_q == PhWait || phase_q == PhNhold))
    else $error("bus driven outside a response phase");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nib_idx_q < NibCount)
    else $error("nibble index past last nibble");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (out_valid_o && (busy_res_o == (phase_q != PhIdle))
                 && (drive_enable_o == drive_q)))
    else $error("result word does not match updated state");

  a_quiet_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !drive_enable_o) |-> (data_out_o == '0))
    else $error("data nibble nonzero while bus released");
`endif

endmodule
`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import sncr_pkg::*;

  localparam int StallLimit = 1000;
  localparam logic [CfgIdxW-1:0] RegTopIndex = '1;
  localparam logic [NibW-1:0] TopNibble = '1;

  typedef enum logic [PhaseW-1:0] {PhIdle, PhSettle, PhAck, PhWait, PhHold} phase_e;

  typedef struct packed {
    logic               strobe;
    logic [NibW-1:0]    bus;
    logic               smp_valid;
    logic [SampleW-1:0] smp;
  } tick_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               strobe_req_i = 1'b0;
  logic [NibW-1:0]    data_in_i = '0;
  logic               sample_valid_i = 1'b0;
  logic [SampleW-1:0] sample_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [NibW-1:0]    data_out_o;
  logic               drive_enable_o;
  logic               led_o;
  logic               busy_res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [RegW-1:0]    cfg_data_i = '0;

  strobe_nibble_command_responder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .strobe_req_i   (strobe_req_i),
    .data_in_i      (data_in_i),
    .sample_valid_i (sample_valid_i),
    .sample_value_i (sample_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .data_out_o     (data_out_o),
    .drive_enable_o (drive_enable_o),
    .led_o          (led_o),
    .busy_res_o     (busy_res_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // responder state as the host sees it
  logic [RegW-1:0]          cf_settle, cf_wait, cf_hold, cf_thr;
  logic                     pr_seen, pr_lvl_at_send, pr_drive;
  logic [NibW-1:0]          pr_cmd, pr_nibble;
  phase_e                   pr_phase;
  logic [RegW-1:0]          pr_count;
  logic [NibIdxW-1:0]       pr_nib;
  logic [ResultBitsDef-1:0] pr_shift, pr_held;

  tick_t   ticks_to_send[$];
  result_t bus_words_due[$];
  tick_t   next_tick;
  result_t got_word, due_word;
  int      send_gap = 0;
  int      take_gap = 0;
  int      stall_cycles = 0;
  int      words_checked = 0;
  int      mismatch_count = 0;
  bit      no_idle = 1'b0;

  function automatic void send_nibble(logic lvl);
    pr_nibble = pr_shift[NibW-1:0];
    pr_shift = pr_shift >> NibW;
    pr_lvl_at_send = lvl;
    pr_drive = 1'b1;
    pr_count = '0;
    pr_phase = PhWait;
  endfunction

  function automatic result_t responder_tick(tick_t t);
    result_t r;
    if (t.smp_valid) pr_held = t.smp[ResultBitsDef-1:0];
    case (pr_phase)
      PhSettle: begin
        if (pr_count != 0) pr_count--;
        if (pr_count == 0) begin
          pr_cmd = t.bus;
          pr_seen = 1'b1;
          pr_phase = PhIdle;
        end
      end
      PhAck: begin
        if (pr_count == 0) begin
          pr_drive = 1'b0;
          pr_phase = PhIdle;
        end else begin
          pr_count--;
        end
      end
      PhWait: begin
        if (t.strobe != pr_lvl_at_send) begin
          pr_count = cf_hold;
          pr_phase = PhHold;
        end else begin
          pr_count++;
          if (pr_count >= cf_wait) begin
            pr_count = cf_hold;
            pr_phase = PhHold;
          end
        end
      end
      PhHold: begin
        if (pr_count == 0) begin
          pr_nib++;
          if (pr_nib >= NibblesSentDef) begin
            pr_nib = '0;
            pr_drive = 1'b0;
            pr_phase = PhIdle;
          end else begin
            send_nibble(t.strobe);
          end
        end else begin
          pr_count--;
        end
      end
      default: begin
        pr_phase = PhIdle;
        if (t.strobe && !pr_seen) begin
          if (cf_settle == 0) begin
            pr_cmd = t.bus;
            pr_seen = 1'b1;
          end else begin
            pr_count = cf_settle;
            pr_phase = PhSettle;
          end
        end else if (!t.strobe && pr_seen) begin
          pr_seen = 1'b0;
          if (pr_cmd == CmdReset || pr_cmd == CmdPing) begin
            if (pr_cmd == CmdReset) pr_held = '0;
            pr_nibble = AckNibble;
            pr_drive = 1'b1;
            pr_count = cf_hold;
            pr_phase = PhAck;
          end else if (pr_cmd == CmdGet) begin
            pr_shift = pr_held;
            pr_nib = '0;
            send_nibble(t.strobe);
          end
        end
      end
    endcase
    r.data_out = pr_drive ? pr_nibble : '0;
    r.drive_enable = pr_drive;
    r.led = pr_held[ResultBitsDef-1 -: 8] < cf_thr;
    r.busy_res = pr_phase != PhIdle;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("word %0d: %s", words_checked, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        bus_words_due.push_back(responder_tick({strobe_req_i, data_in_i, sample_valid_i,
                                                sample_value_i}));
        send_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (send_gap == 0 && ticks_to_send.size() != 0) begin
        next_tick = ticks_to_send.pop_front();
        {strobe_req_i, data_in_i, sample_valid_i, sample_value_i} <= next_tick;
        in_valid_i <= 1'b1;
      end else begin
        if (send_gap != 0) send_gap--;
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_word = {data_out_o, drive_enable_o, led_o, busy_res_o};
        words_checked++;
        if (bus_words_due.size() == 0) begin
          flag_mismatch("output word with nothing expected");
        end else begin
          due_word = bus_words_due.pop_front();
          if (got_word.data_out !== due_word.data_out)
            flag_mismatch($sformatf("data_out %h, expected %h", got_word.data_out,
                                    due_word.data_out));
          if (got_word.drive_enable !== due_word.drive_enable)
            flag_mismatch($sformatf("drive_enable %b, expected %b", got_word.drive_enable,
                                    due_word.drive_enable));
          if (got_word.led !== due_word.led)
            flag_mismatch($sformatf("led %b, expected %b", got_word.led, due_word.led));
          if (got_word.busy_res !== due_word.busy_res)
            flag_mismatch($sformatf("busy_res %b, expected %b", got_word.busy_res,
                                    due_word.busy_res));
        end
        take_gap = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (take_gap != 0) begin
        take_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegSettleTicks:  cf_settle = val;
      RegWaitLimit:    cf_wait = val;
      RegHoldTicks:    cf_hold = val;
      RegLedThreshold: cf_thr = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_timing(input logic [RegW-1:0] settle, wait_lim, hold, thr);
    write_reg(RegSettleTicks, settle);
    write_reg(RegWaitLimit, wait_lim);
    write_reg(RegHoldTicks, hold);
    write_reg(RegLedThreshold, thr);
    if ($urandom_range(0, 3) == 0)
      write_reg(CfgIdxW'($urandom_range(RegLedThreshold + 1, RegTopIndex)), RegW'($urandom));
  endtask

  task automatic drain_responses();
    do @(negedge clk_i);
    while (ticks_to_send.size() != 0 || in_valid_i || bus_words_due.size() != 0);
  endtask

  function automatic void push_tick(logic lvl, logic [NibW-1:0] bus);
    tick_t t;
    t.strobe = lvl;
    t.bus = bus;
    t.smp_valid = ($urandom_range(0, 7) == 0);
    t.smp = SampleW'($urandom);
    ticks_to_send.push_back(t);
  endfunction

  // well-formed host transaction: strobe up, settle, strobe down, then follow the reply
  task automatic queue_command(input logic [NibW-1:0] cmd);
    int  wait_eff;
    int  run;
    logic lvl;
    wait_eff = (cf_wait == 0) ? 1 : cf_wait;
    repeat ($urandom_range(1, 3)) push_tick(1'b0, NibW'($urandom));
    repeat (cf_settle + 1) push_tick(1'b1, cmd);
    repeat ($urandom_range(0, 2)) push_tick(1'b1, NibW'($urandom));
    push_tick(1'b0, NibW'($urandom));
    lvl = 1'b0;
    if (cmd == CmdGet) begin
      repeat (NibblesSentDef) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat (wait_eff) push_tick(lvl, NibW'($urandom));
        end else begin
          run = $urandom_range(0, wait_eff - 1);
          if (run > 6 && $urandom_range(0, 3) != 0) run = $urandom_range(0, 6);
          repeat (run) push_tick(lvl, NibW'($urandom));
          lvl = !lvl;
          push_tick(lvl, NibW'($urandom));
        end
        repeat (cf_hold + 1) push_tick(lvl, NibW'($urandom));
      end
    end else if (cmd == CmdReset || cmd == CmdPing) begin
      repeat (cf_hold + 1) push_tick(1'b0, NibW'($urandom));
    end
    repeat ($urandom_range(1, 3)) push_tick(1'b0, NibW'($urandom));
  endtask

  task automatic queue_phase(input int n_ticks);
    int pick;
    while (ticks_to_send.size() < n_ticks) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) queue_command(CmdGet);
      else if (pick < 5) queue_command(CmdPing);
      else if (pick < 6) queue_command(CmdReset);
      else if (pick < 7) queue_command(NibW'($urandom_range(CmdGet + 1, TopNibble)));
      else repeat ($urandom_range(1, 8)) push_tick(1'($urandom), NibW'($urandom));
    end
  endtask

  initial begin
    cf_settle = SettleTicksRst;
    cf_wait = WaitLimitRst;
    cf_hold = HoldTicksRst;
    cf_thr = LedThresholdRst;
    pr_seen = 1'b0;
    pr_cmd = '0;
    pr_phase = PhIdle;
    pr_count = '0;
    pr_nib = '0;
    pr_shift = '0;
    pr_lvl_at_send = 1'b0;
    pr_held = '0;
    pr_nibble = '0;
    pr_drive = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values; LED right at the threshold, then just below it
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b1, 10'h1FC});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b1, 10'h1FB});
    queue_command(CmdPing);
    drain_responses();

    // zero settle, zero wait limit, zero hold
    set_timing(8'd0, 8'd0, 8'd0, 8'hFF);
    write_reg(RegTopIndex, 8'hFF);
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b1, 10'h3FF});
    ticks_to_send.push_back(tick_t'{1'b1, CmdPing, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'hF, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b1, CmdGet, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b1, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    // reset command with a sample on the strobe-release tick: sample is cleared
    ticks_to_send.push_back(tick_t'{1'b1, CmdReset, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b1, 10'h2A5});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b1, TopNibble, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'h0, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b1, CmdGet, 1'b1, 10'h000});
    ticks_to_send.push_back(tick_t'{1'b0, 4'hF, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b0, 4'hF, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b1, 4'hF, 1'b0, 10'h0});
    ticks_to_send.push_back(tick_t'{1'b1, 4'hF, 1'b0, 10'h0});
    drain_responses();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 4) begin
        set_timing(8'hFF, 8'hFF, 8'd0, 8'd0);
        no_idle = 1'b0;
        queue_command(CmdPing);
        drain_responses();
      end
      set_timing(RegW'($urandom_range(0, 4)), RegW'($urandom_range(0, 5)),
                 RegW'($urandom_range(0, 4)), RegW'($urandom));
      no_idle = ($urandom_range(0, 3) == 0);
      queue_phase(20);
      drain_responses();
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
